/* src/pmig_pkg.sv */
package pmig_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned IDX_W   = 25;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CIDX_W  = 3;

  typedef enum logic [2:0] {
    FMT_FULL  = 3'd0,
    FMT_BAND  = 3'd1,
    FMT_UPPER = 3'd2,
    FMT_LOWER = 3'd3,
    FMT_SYM   = 3'd4,
    FMT_DIAG  = 3'd5,
    FMT_SBAND = 3'd6
  } fmt_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_FORMAT = 3'd0,
    REG_ROWS   = 3'd1,
    REG_COLS   = 3'd2,
    REG_SUB    = 3'd3,
    REG_SUPER  = 3'd4,
    REG_LTRANS = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] row_index;
    logic [POS_W-1:0] column_index;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] flat_index;
    logic             index_valid;
    logic [POS_W-1:0] next_row;
    logic [POS_W-1:0] next_column;
    logic             walk_done;
  } out_res_t;

  typedef struct packed {
    fmt_t             storage_format;
    logic [DIM_W-1:0] total_rows;
    logic [DIM_W-1:0] total_columns;
    logic [DIM_W-1:0] sub_diags;
    logic [DIM_W-1:0] super_diags;
    logic             lower_transposed;
  } cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    clamp_dim = (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

  // a count of MAX_DIM stands for rows-1 (0 for an empty matrix)
  function automatic logic [DIM_W-1:0] eff_diags(input logic [DIM_W-1:0] rows,
                                                  input logic [DIM_W-1:0] d);
    if (d != DIM_W'(MAX_DIM)) begin
      eff_diags = d;
    end else if (rows != '0) begin
      eff_diags = rows - DIM_W'(1);
    end else begin
      eff_diags = '0;
    end
  endfunction

endpackage

/* src/pmig_index.sv */
module pmig_index (
  input  pmig_pkg::cfg_t                 cfg,
  input  pmig_pkg::in_req_t              req,
  output logic [pmig_pkg::IDX_W-1:0]     flat_index,
  output logic                           index_valid
);
  import pmig_pkg::*;

  logic [DIM_W-1:0]    rows;
  logic [DIM_W-1:0]    sb;
  logic [DIM_W-1:0]    sp;
  logic [POS_W-1:0]    r;
  logic [POS_W-1:0]    c;
  logic [POS_W-1:0]    lo;
  logic [POS_W-1:0]    hi;
  logic [POS_W-1:0]    gap;
  logic [DIM_W-1:0]    rc_diff;
  logic [DIM_W-1:0]    cr_diff;
  logic [14:0]         band_w;
  logic [POS_W-1:0]    mul_a;
  logic signed [15:0]  mul_b;
  logic signed [28:0]  prod;
  logic                halve;
  logic [IDX_W-1:0]    offs;
  logic [IDX_W-1:0]    prod_term;
  logic                valid;

  always_comb begin
    r       = req.row_index;
    c       = req.column_index;
    rows    = clamp_dim(cfg.total_rows);
    sb      = eff_diags(rows, cfg.sub_diags);
    sp      = eff_diags(rows, cfg.super_diags);
    lo      = (r <= c) ? r : c;
    hi      = (r <= c) ? c : r;
    gap     = hi - lo;
    rc_diff = DIM_W'(r) - DIM_W'(c);
    cr_diff = DIM_W'(c) - DIM_W'(r);
    band_w  = 15'(sb) + 15'(sp) + 15'd1;
  end

  // every format reduces to offs + a*b, halved for the triangular ones
  always_comb begin
    mul_a = c;
    mul_b = '0;
    halve = 1'b0;
    offs  = IDX_W'(r);
    valid = 1'b0;
    case (cfg.storage_format)
      FMT_FULL: begin
        mul_b = 16'(rows);
        valid = 1'b1;
      end
      FMT_BAND: begin
        mul_b = 16'(band_w);
        offs  = IDX_W'(sp) + IDX_W'(r) - IDX_W'(c);
        valid = ((c <= r) && (rc_diff <= sb)) || ((c > r) && (cr_diff <= sp));
      end
      FMT_UPPER: begin
        mul_b = 16'(c) + 16'sd1;
        halve = 1'b1;
        valid = (r <= c);
      end
      FMT_LOWER: begin
        // signed: goes negative when the column count is small
        mul_b = 16'({clamp_dim(cfg.total_columns), 1'b0}) - 16'(c) - 16'sd1;
        halve = 1'b1;
        valid = (r >= c);
      end
      FMT_SYM: begin
        mul_a = hi;
        mul_b = 16'(hi) + 16'sd1;
        halve = 1'b1;
        offs  = IDX_W'(lo);
        valid = 1'b1;
      end
      FMT_DIAG: begin
        valid = (r == c);
      end
      FMT_SBAND: begin
        mul_a = hi;
        mul_b = 16'(sp) + 16'sd1;
        offs  = IDX_W'(sp) - IDX_W'(gap);
        valid = (DIM_W'(gap) <= sp);
      end
      default: begin
        valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    prod        = 29'($signed({1'b0, mul_a})) * 29'(mul_b);
    prod_term   = halve ? prod[IDX_W:1] : prod[IDX_W-1:0];
    flat_index  = valid ? (prod_term + offs) : '0;
    index_valid = valid;
  end

endmodule

/* src/pmig_walk.sv */
module pmig_walk (
  input  pmig_pkg::cfg_t              cfg,
  input  pmig_pkg::in_req_t           req,
  output logic [pmig_pkg::POS_W-1:0]  next_row,
  output logic [pmig_pkg::POS_W-1:0]  next_column,
  output logic                        walk_done
);
  import pmig_pkg::*;

  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] cols;
  logic [DIM_W-1:0] wr;
  logic [DIM_W-1:0] wc;
  logic [DIM_W-1:0] lim;
  logic             done;

  always_comb begin
    rows = clamp_dim(cfg.total_rows);
    cols = clamp_dim(cfg.total_columns);
    wr   = DIM_W'(req.row_index);
    wc   = DIM_W'(req.column_index);
    lim  = cols;
    done = 1'b0;
    case (cfg.storage_format)
      FMT_FULL, FMT_SYM: begin
        if (wr < rows) wr = wr + DIM_W'(1);
        if (wr >= rows) begin
          wr = '0;
          wc = wc + DIM_W'(1);
        end
        done = (wc >= cols);
      end
      FMT_UPPER: begin
        if (wr <= wc) wr = wr + DIM_W'(1);
        if (wr > wc) begin
          wc = wc + DIM_W'(1);
          wr = '0;
        end
        done = (wc >= lim);
      end
      FMT_LOWER: begin
        if (cfg.lower_transposed) begin
          // upper walk on the swapped position, result not swapped back
          wr  = DIM_W'(req.column_index);
          wc  = DIM_W'(req.row_index);
          lim = rows;
          if (wr <= wc) wr = wr + DIM_W'(1);
          if (wr > wc) begin
            wc = wc + DIM_W'(1);
            wr = '0;
          end
          done = (wc >= lim);
        end else begin
          if (wr < rows) wr = wr + DIM_W'(1);
          if (wr >= rows) begin
            wc = wc + DIM_W'(1);
            wr = wc;
          end
          done = (wc >= cols);
        end
      end
      FMT_DIAG: begin
        if (wr < rows) begin
          wr = wr + DIM_W'(1);
          wc = wc + DIM_W'(1);
        end
        done = (wr >= rows);
      end
      FMT_BAND, FMT_SBAND: begin
        done = 1'b0;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    next_row    = done ? '0 : wr[POS_W-1:0];
    next_column = done ? '0 : wc[POS_W-1:0];
    walk_done   = done;
  end

endmodule

/* src/packed_matrix_index_generator.sv */
// Packed matrix index generator.
// A taken request passes the request register, then the result register raises out_valid.
// Throughput: one request per clock; busy is never raised and the receiver cannot stall.
// Cycles are set by the request and result registers; one 13x16 multiply sits between them.
// Synchronous active-low reset drops requests in flight and restores register defaults.
module packed_matrix_index_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pmig_pkg::in_req_t             in_data,
  output logic                          out_valid,
  output pmig_pkg::out_res_t            out_data,
  input  logic                          cfg_we,
  input  logic [pmig_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [pmig_pkg::CFG_W-1:0]    cfg_wdata
);
  import pmig_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     in_valid_r;
  in_req_t  in_data_r;
  logic     out_valid_r;
  out_res_t out_data_r;
  out_res_t res_nxt;

  assign busy = 1'b0;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FORMAT: cfg_nxt.storage_format   = fmt_t'(cfg_wdata[2:0]);
        REG_ROWS:   cfg_nxt.total_rows       = cfg_wdata;
        REG_COLS:   cfg_nxt.total_columns    = cfg_wdata;
        REG_SUB:    cfg_nxt.sub_diags        = cfg_wdata;
        REG_SUPER:  cfg_nxt.super_diags      = cfg_wdata;
        REG_LTRANS: cfg_nxt.lower_transposed = cfg_wdata[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.storage_format   <= FMT_FULL;
      cfg_r.total_rows       <= '0;
      cfg_r.total_columns    <= '0;
      cfg_r.sub_diags        <= CFG_W'(MAX_DIM);
      cfg_r.super_diags      <= CFG_W'(MAX_DIM);
      cfg_r.lower_transposed <= 1'b0;
      in_valid_r             <= 1'b0;
      out_valid_r            <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) in_data_r <= in_data;
    if (in_valid_r) out_data_r <= res_nxt;
  end

  pmig_index u_index (
    .cfg         (cfg_r),
    .req         (in_data_r),
    .flat_index  (res_nxt.flat_index),
    .index_valid (res_nxt.index_valid)
  );

  pmig_walk u_walk (
    .cfg         (cfg_r),
    .req         (in_data_r),
    .next_row    (res_nxt.next_row),
    .next_column (res_nxt.next_column),
    .walk_done   (res_nxt.walk_done)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/pmig_chk.sv */
module pmig_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input pmig_pkg::out_res_t  out_data,
  input logic                out_valid
);
  import pmig_pkg::*;

  // every request taken out of reset comes back with out_valid, through the request and result registers
  a_req_returns: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 2) && $past(rst_n, 1) && $past(start && !busy, 2)) |-> out_valid)
    else $error("request lost");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 2) && $past(rst_n, 1) && out_valid) |-> $past(start && !busy, 2))
    else $error("result without request");

  a_unstored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.index_valid) |-> (out_data.flat_index == '0))
    else $error("index not zero for unstored element");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.walk_done) |->
      (out_data.next_row == '0 && out_data.next_column == '0))
    else $error("walk position not cleared when done");

endmodule

bind packed_matrix_index_generator pmig_chk u_pmig_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);
